// ===== src/plr_pkg.sv =====
// Shared types, constants and codes for the pinned LRU slot cache.
package plr_pkg;

  localparam int SLOTS   = 16;
  localparam int ID_BITS = 16;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam int SLOT_LIMIT_W   = 5;
  localparam int EXPERT_LIMIT_W = 17;
  localparam int CFG_DATA_W     = 17;
  localparam int CFG_IDX_W      = 1;
  localparam int STAMP_W        = 32;
  localparam int COUNT_W        = 32;
  localparam int OWNER_W        = 4;
  localparam int SEL_W          = 4;

  localparam logic [SLOT_LIMIT_W-1:0]   SLOT_LIMIT_RESET   = 5'd16;
  localparam logic [EXPERT_LIMIT_W-1:0] EXPERT_LIMIT_RESET = 17'd256;
  localparam logic [OWNER_W-1:0]        OWNER_UNASSIGNED   = 4'd0;
  localparam logic [OWNER_W-1:0]        OWNER_SHARED       = 4'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOT_LIMIT   = 1'b0,
    CFG_EXPERT_LIMIT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_REQUEST = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_PIN     = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_NO_SLOT  = 3'd2,
    ST_RELEASED = 3'd3,
    ST_IGNORED  = 3'd4,
    ST_PINNED   = 3'd5,
    ST_SKIPPED  = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_HIT   = 3'd1,
    CMD_FILL  = 3'd2,
    CMD_CLEAR = 3'd3,
    CMD_PIN   = 3'd4
  } cmd_op_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] expert;
    logic [3:0]  slot_select;
    logic        has_owner;
    logic [3:0]  owner_tag;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot_index;
    logic        evicted;
    logic [31:0] slot_hits;
    logic [4:0]  occupied;
    logic [31:0] request_total;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] eviction_total;
    logic [31:0] load_total;
  } out_t;

  typedef struct packed {
    logic [CNT_W-1:0]   pos;
    logic [ID_BITS-1:0] id;
    logic [SEL_W-1:0]   sel;
    logic               found;
    logic [IDX_W-1:0]   hit_slot;
    logic [COUNT_W-1:0] hit_cnt;
    logic               have;
    logic               empty;
    logic [IDX_W-1:0]   best_slot;
    logic [STAMP_W-1:0] best_stamp;
    logic               dup;
    logic               sel_locked;
    logic [CNT_W-1:0]   occ;
  } scan_pkt_t;

  typedef struct packed {
    cmd_op_e            op;
    logic [ID_BITS-1:0] tag;
    logic               owner_load;
    logic [OWNER_W-1:0] owner;
    logic               evict;
    logic [STAMP_W-1:0] stamp;
  } wr_cmd_t;

endpackage

// ===== src/plr_cell.sv =====
// One cache slot: holds its entry and updates the scan packet passing through.
module plr_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [plr_pkg::CNT_W-1:0]     lim_i,
  input  plr_pkg::scan_pkt_t            pkt_i,
  output plr_pkg::scan_pkt_t            pkt_o,
  input  plr_pkg::wr_cmd_t              cmd_i,
  input  logic                          sel_i
);

  logic [plr_pkg::ID_BITS-1:0] tag_r, tag_nxt;
  logic                        valid_r, valid_nxt;
  logic                        locked_r, locked_nxt;
  logic [plr_pkg::COUNT_W-1:0] hits_r, hits_nxt;
  logic [plr_pkg::STAMP_W-1:0] stamp_r, stamp_nxt;
  logic [plr_pkg::OWNER_W-1:0] owner_r, owner_nxt;
  plr_pkg::scan_pkt_t          pkt_r, pkt_nxt;
  logic                        active;
  logic                        match;

  always_comb begin
    active  = pkt_i.pos < lim_i;
    match   = valid_r && (tag_r == pkt_i.id);
    pkt_nxt = pkt_i;
    pkt_nxt.pos = pkt_i.pos + 1'b1;
    if (active && match && !pkt_i.found) begin
      pkt_nxt.found    = 1'b1;
      pkt_nxt.hit_slot = plr_pkg::IDX_W'(pkt_i.pos);
      pkt_nxt.hit_cnt  = hits_r;
    end
    if (active && !locked_r && !pkt_i.empty) begin
      if (!valid_r) begin
        pkt_nxt.best_slot = plr_pkg::IDX_W'(pkt_i.pos);
        pkt_nxt.have      = 1'b1;
        pkt_nxt.empty     = 1'b1;
      end else if (!pkt_i.have || (stamp_r < pkt_i.best_stamp)) begin
        pkt_nxt.best_slot  = plr_pkg::IDX_W'(pkt_i.pos);
        pkt_nxt.best_stamp = stamp_r;
        pkt_nxt.have       = 1'b1;
      end
    end
    if (active && locked_r && match) begin
      pkt_nxt.dup = 1'b1;
    end
    if (32'(pkt_i.pos) == 32'(pkt_i.sel)) begin
      pkt_nxt.sel_locked = locked_r;
    end
    if (active && valid_r) begin
      pkt_nxt.occ = pkt_i.occ + 1'b1;
    end
  end

  always_comb begin
    tag_nxt    = tag_r;
    valid_nxt  = valid_r;
    locked_nxt = locked_r;
    hits_nxt   = hits_r;
    stamp_nxt  = stamp_r;
    owner_nxt  = owner_r;
    if (sel_i) begin
      case (cmd_i.op)
        plr_pkg::CMD_HIT: begin
          hits_nxt  = hits_r + 1'b1;
          stamp_nxt = cmd_i.stamp;
        end
        plr_pkg::CMD_FILL: begin
          tag_nxt   = cmd_i.tag;
          valid_nxt = 1'b1;
          hits_nxt  = plr_pkg::COUNT_W'(1);
          stamp_nxt = cmd_i.stamp;
          if (cmd_i.owner_load) begin
            owner_nxt = cmd_i.owner;
          end else if (cmd_i.evict) begin
            owner_nxt = plr_pkg::OWNER_UNASSIGNED;
          end
        end
        plr_pkg::CMD_CLEAR: begin
          tag_nxt   = '0;
          valid_nxt = 1'b0;
          hits_nxt  = '0;
          stamp_nxt = '0;
          owner_nxt = plr_pkg::OWNER_UNASSIGNED;
        end
        plr_pkg::CMD_PIN: begin
          tag_nxt    = cmd_i.tag;
          valid_nxt  = 1'b1;
          locked_nxt = 1'b1;
          hits_nxt   = plr_pkg::COUNT_W'(1);
          stamp_nxt  = cmd_i.stamp;
          owner_nxt  = plr_pkg::OWNER_SHARED;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r    <= '0;
      valid_r  <= 1'b0;
      locked_r <= 1'b0;
      hits_r   <= '0;
      stamp_r  <= '0;
      owner_r  <= plr_pkg::OWNER_UNASSIGNED;
    end else begin
      tag_r    <= tag_nxt;
      valid_r  <= valid_nxt;
      locked_r <= locked_nxt;
      hits_r   <= hits_nxt;
      stamp_r  <= stamp_nxt;
      owner_r  <= owner_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pkt_r <= pkt_nxt;
  end

  assign pkt_o = pkt_r;

endmodule

// ===== src/pinned_lru_slot_cache_core.sv =====
// Top level of the pinned LRU slot cache: sequencer, totals and the row of slot cells.
// Each transaction runs through these steps: the sequencer accepts it, a lookup pass
// sends a scan packet along the row of slot cells, an update step writes the chosen
// slot and the totals, a second pass through the same row counts the occupied slots,
// and a finish step and a push step place the result in the output register once it
// is free. The length of the cell row sets both passes. A new transaction is accepted
// while the previous result still waits in the output register.
module pinned_lru_slot_cache_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  plr_pkg::in_t                       in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output plr_pkg::out_t                      out_data,
  input  logic                               cfg_we,
  input  logic [plr_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [plr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_WRITE = 6'b000100,
    S_COUNT = 6'b001000,
    S_FIN   = 6'b010000,
    S_PUSH  = 6'b100000
  } state_t;

  state_t                                state_r, state_nxt;
  logic [plr_pkg::IDX_W-1:0]             cnt_r, cnt_nxt;
  plr_pkg::in_t                          item_r;
  logic [plr_pkg::SLOT_LIMIT_W-1:0]      slot_limit_r;
  logic [plr_pkg::EXPERT_LIMIT_W-1:0]    expert_limit_r;
  logic [plr_pkg::STAMP_W-1:0]           use_clock_r, use_clock_nxt;
  logic [plr_pkg::CNT_W-1:0]             next_pin_r, next_pin_nxt;
  logic [plr_pkg::COUNT_W-1:0]           req_total_r, hit_total_r, miss_total_r;
  logic [plr_pkg::COUNT_W-1:0]           evict_total_r, load_total_r;
  logic [2:0]                            res_status_r, res_status_nxt;
  logic [plr_pkg::IDX_W-1:0]             res_index_r, res_index_nxt;
  logic                                  res_evicted_r, res_evicted_nxt;
  logic [plr_pkg::COUNT_W-1:0]           res_hits_r, res_hits_nxt;
  logic [plr_pkg::CNT_W-1:0]             occ_r;
  plr_pkg::out_t                         out_data_r;
  logic                                  out_valid_r;

  logic [plr_pkg::CNT_W-1:0]             lim;
  logic [plr_pkg::ID_BITS-1:0]           id;
  logic [plr_pkg::STAMP_W-1:0]           tick;
  logic                                  pass_end;
  logic                                  out_free;
  plr_pkg::scan_pkt_t                    launch;
  plr_pkg::scan_pkt_t                    last;
  plr_pkg::scan_pkt_t                    chain [0:plr_pkg::SLOTS];
  plr_pkg::wr_cmd_t                      cmd;
  logic [plr_pkg::IDX_W-1:0]             tgt;
  logic [plr_pkg::SLOTS-1:0]             wr_sel;
  logic                                  do_hit, do_fill, do_pin, do_req;

  assign lim = (32'(slot_limit_r) > plr_pkg::SLOTS) ? plr_pkg::CNT_W'(plr_pkg::SLOTS)
                                                    : plr_pkg::CNT_W'(slot_limit_r);
  assign id       = plr_pkg::ID_BITS'(item_r.expert);
  assign tick     = (use_clock_r == '1) ? use_clock_r : use_clock_r + 1'b1;
  assign pass_end = (cnt_r == plr_pkg::IDX_W'(plr_pkg::SLOTS - 1));
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    launch     = '0;
    launch.id  = id;
    launch.sel = item_r.slot_select;
  end

  assign chain[0] = launch;
  assign last     = chain[plr_pkg::SLOTS];

  genvar g;
  generate
    for (g = 0; g < plr_pkg::SLOTS; g++) begin : g_cell
      plr_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .lim_i (lim),
        .pkt_i (chain[g]),
        .pkt_o (chain[g+1]),
        .cmd_i (cmd),
        .sel_i (wr_sel[g])
      );
    end
  endgenerate

  always_comb begin
    cmd             = '0;
    cmd.op          = plr_pkg::CMD_NONE;
    cmd.tag         = id;
    cmd.owner_load  = item_r.has_owner;
    cmd.owner       = item_r.owner_tag;
    cmd.evict       = !last.empty;
    cmd.stamp       = tick;
    tgt             = '0;
    do_hit          = 1'b0;
    do_fill         = 1'b0;
    do_pin          = 1'b0;
    do_req          = 1'b0;
    res_status_nxt  = plr_pkg::ST_IGNORED;
    res_index_nxt   = '0;
    res_evicted_nxt = 1'b0;
    res_hits_nxt    = '0;
    next_pin_nxt    = next_pin_r;
    use_clock_nxt   = use_clock_r;
    unique case (item_r.mode)
      plr_pkg::MODE_REQUEST: begin
        do_req = 1'b1;
        if (last.found) begin
          do_hit         = 1'b1;
          cmd.op         = plr_pkg::CMD_HIT;
          tgt            = last.hit_slot;
          res_status_nxt = plr_pkg::ST_HIT;
          res_index_nxt  = last.hit_slot;
          res_hits_nxt   = last.hit_cnt + 1'b1;
          use_clock_nxt  = tick;
        end else if (last.have) begin
          do_fill         = 1'b1;
          cmd.op          = plr_pkg::CMD_FILL;
          tgt             = last.best_slot;
          res_status_nxt  = plr_pkg::ST_MISS;
          res_index_nxt   = last.best_slot;
          res_evicted_nxt = !last.empty;
          res_hits_nxt    = plr_pkg::COUNT_W'(1);
          use_clock_nxt   = tick;
        end else begin
          res_status_nxt = plr_pkg::ST_NO_SLOT;
        end
      end
      plr_pkg::MODE_RELEASE: begin
        res_index_nxt = plr_pkg::IDX_W'(item_r.slot_select);
        if ((32'(item_r.slot_select) < 32'(lim)) && !last.sel_locked) begin
          cmd.op         = plr_pkg::CMD_CLEAR;
          tgt            = plr_pkg::IDX_W'(item_r.slot_select);
          res_status_nxt = plr_pkg::ST_RELEASED;
        end else begin
          res_status_nxt = plr_pkg::ST_IGNORED;
        end
      end
      plr_pkg::MODE_PIN: begin
        if ((32'(id) >= 32'(expert_limit_r)) || last.dup || (next_pin_r >= lim)) begin
          res_status_nxt = plr_pkg::ST_SKIPPED;
        end else begin
          do_pin         = 1'b1;
          cmd.op         = plr_pkg::CMD_PIN;
          tgt            = plr_pkg::IDX_W'(next_pin_r);
          res_status_nxt = plr_pkg::ST_PINNED;
          res_index_nxt  = plr_pkg::IDX_W'(next_pin_r);
          res_hits_nxt   = plr_pkg::COUNT_W'(1);
          next_pin_nxt   = next_pin_r + 1'b1;
          use_clock_nxt  = tick;
        end
      end
      default: begin
      end
    endcase
    if (state_r != S_WRITE) begin
      cmd.op = plr_pkg::CMD_NONE;
    end
  end

  always_comb begin
    wr_sel      = '0;
    wr_sel[tgt] = (cmd.op != plr_pkg::CMD_NONE);
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (pass_end) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        cnt_nxt   = '0;
        state_nxt = S_COUNT;
      end
      S_COUNT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (pass_end) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      cnt_r          <= '0;
      slot_limit_r   <= plr_pkg::SLOT_LIMIT_RESET;
      expert_limit_r <= plr_pkg::EXPERT_LIMIT_RESET;
      use_clock_r    <= '0;
      next_pin_r     <= '0;
      req_total_r    <= '0;
      hit_total_r    <= '0;
      miss_total_r   <= '0;
      evict_total_r  <= '0;
      load_total_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          plr_pkg::CFG_SLOT_LIMIT:
            slot_limit_r <= cfg_wdata[plr_pkg::SLOT_LIMIT_W-1:0];
          plr_pkg::CFG_EXPERT_LIMIT:
            expert_limit_r <= cfg_wdata[plr_pkg::EXPERT_LIMIT_W-1:0];
          default: begin
          end
        endcase
      end
      if (state_r == S_WRITE) begin
        use_clock_r <= use_clock_nxt;
        next_pin_r  <= next_pin_nxt;
        if (do_req) begin
          req_total_r <= req_total_r + 1'b1;
          if (do_hit) begin
            hit_total_r <= hit_total_r + 1'b1;
          end else begin
            miss_total_r <= miss_total_r + 1'b1;
          end
        end
        if (do_fill && !last.empty) begin
          evict_total_r <= evict_total_r + 1'b1;
        end
        if (do_fill || do_pin) begin
          load_total_r <= load_total_r + 1'b1;
        end
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if ((state_r == S_PUSH) && out_free) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (state_r == S_WRITE) begin
      res_status_r  <= res_status_nxt;
      res_index_r   <= res_index_nxt;
      res_evicted_r <= res_evicted_nxt;
      res_hits_r    <= res_hits_nxt;
    end
    if (state_r == S_FIN) begin
      occ_r <= last.occ;
    end
    if ((state_r == S_PUSH) && out_free) begin
      out_data_r.status         <= res_status_r;
      out_data_r.slot_index     <= 4'(res_index_r);
      out_data_r.evicted        <= res_evicted_r;
      out_data_r.slot_hits      <= res_hits_r;
      out_data_r.occupied       <= 5'(occ_r);
      out_data_r.request_total  <= req_total_r;
      out_data_r.hit_total      <= hit_total_r;
      out_data_r.miss_total     <= miss_total_r;
      out_data_r.eviction_total <= evict_total_r;
      out_data_r.load_total     <= load_total_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_pin_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_pin_r <= plr_pkg::CNT_W'(plr_pkg::SLOTS))
    else $error("pin pointer ran past the last slot");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(wr_sel))
    else $error("more than one slot written in a cycle");

  a_write_only_in_update: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_sel != '0) |-> (state_r == S_WRITE))
    else $error("slot written outside the update cycle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction accepted during a lookup");

  a_result_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_PUSH))
    else $error("result presented without a completed transaction");

endmodule
